>>> hw/rtl/trwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace record window delta: shared package
// Payload types of the request, response and internal queue transactions,
// and the default sizes of the window.
// ----------------------------------------------------------------------------
package trwd_pkg;

   localparam int WINDOW_SLOTS_DEFAULT = 3;
   localparam int MAX_ARGS_DEFAULT = 8;
   localparam int TOKEN_WIDTH_DEFAULT = 32;

   localparam int TOKEN_PORT_WIDTH = 32;
   localparam int TIME_WIDTH = 32;
   localparam int ARG_PORT_COUNT = 8;
   localparam int ARG_TOTAL_WIDTH = 4;
   localparam int REF_SLOT_WIDTH = 2;
   localparam int ARG_POS_WIDTH = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [TIME_WIDTH-1:0] start_time;
      logic signed [TIME_WIDTH-1:0] duration;
      logic [TOKEN_PORT_WIDTH-1:0] func_token;
      logic [ARG_TOTAL_WIDTH-1:0] arg_total;
      logic [TOKEN_PORT_WIDTH-1:0] arg_a;
      logic [TOKEN_PORT_WIDTH-1:0] arg_b;
      logic [TOKEN_PORT_WIDTH-1:0] arg_c;
      logic [TOKEN_PORT_WIDTH-1:0] arg_d;
      logic [TOKEN_PORT_WIDTH-1:0] arg_e;
      logic [TOKEN_PORT_WIDTH-1:0] arg_f;
      logic [TOKEN_PORT_WIDTH-1:0] arg_g;
      logic [TOKEN_PORT_WIDTH-1:0] arg_h;
   } req_payload_type;

   typedef struct packed {
      logic is_header;
      logic compressed;
      logic [REF_SLOT_WIDTH-1:0] ref_slot;
      logic signed [TIME_WIDTH-1:0] out_start;
      logic signed [TIME_WIDTH-1:0] out_duration;
      logic [TOKEN_PORT_WIDTH-1:0] out_func;
      logic [ARG_POS_WIDTH-1:0] arg_position;
      logic [TOKEN_PORT_WIDTH-1:0] arg_value;
      logic last;
   } rsp_payload_type;

   // One classified record: header contents and the arguments to be sent.
   typedef struct packed {
      logic compressed;
      logic [REF_SLOT_WIDTH-1:0] ref_slot;
      logic signed [TIME_WIDTH-1:0] start_time;
      logic signed [TIME_WIDTH-1:0] duration;
      logic [TOKEN_PORT_WIDTH-1:0] func_token;
      logic [ARG_PORT_COUNT-1:0] emit_mask;
      logic [ARG_PORT_COUNT-1:0][TOKEN_PORT_WIDTH-1:0] args;
   } entry_type;

endpackage

>>> hw/rtl/trwd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace record window delta: stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface trwd_stream_if #(
   parameter type payload_type = logic
) ();

   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

>>> hw/rtl/trace_record_window_delta_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace record window delta compressor
// Encodes each trace record against a window of recent records.
// ----------------------------------------------------------------------------
// The request channel takes one trace record per transaction. Each record
// yields a header transaction followed by one transaction per argument that
// is sent; the last transaction of a record has last set.
// A full record yields up to 9 response transactions: one header and eight
// arguments. The response register moves one transaction per cycle while
// rsp_chan.ready is not held low, and this sets the sustained rate.
// The header of a record passes through the queue, the sequencer's record
// register and the response register before reaching the response channel.
// A two-entry queue between the classifier and the result sequencer lets the
// request side keep accepting while responses drain; requests stall only when
// that queue is full.
// When the receiver holds rsp_chan.ready low, the current response stays on
// the channel unchanged and the queue fills before requests are refused.
// Reset empties the queue and the response register and marks the window
// empty, so the next record is sent in full and fills every slot.
// ----------------------------------------------------------------------------
module trace_record_window_delta_core #(
   parameter int WINDOW_SLOTS = trwd_pkg::WINDOW_SLOTS_DEFAULT,
   parameter int MAX_ARGS = trwd_pkg::MAX_ARGS_DEFAULT,
   parameter int TOKEN_WIDTH = trwd_pkg::TOKEN_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   trwd_stream_if.sink req_chan,
   trwd_stream_if.source rsp_chan
);

   trwd_stream_if #(.payload_type(trwd_pkg::entry_type)) front_to_queue ();
   trwd_stream_if #(.payload_type(trwd_pkg::entry_type)) queue_to_back ();

   trwd_front #(
      .WINDOW_SLOTS(WINDOW_SLOTS),
      .MAX_ARGS(MAX_ARGS),
      .TOKEN_WIDTH(TOKEN_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .entry_out(front_to_queue.source)
   );

   trwd_queue #(
      .DEPTH(trwd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_chan(front_to_queue.sink),
      .pop_chan(queue_to_back.source)
   );

   trwd_back u_back (
      .clock(clock),
      .reset(reset),
      .entry_in(queue_to_back.sink),
      .rsp(rsp_chan)
   );

endmodule

>>> hw/rtl/trwd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace record window delta: front end
// Holds the record window, compares each incoming record against every slot,
// picks the reference slot and pushes a classified entry into the queue.
// ----------------------------------------------------------------------------
module trwd_front #(
   parameter int WINDOW_SLOTS = trwd_pkg::WINDOW_SLOTS_DEFAULT,
   parameter int MAX_ARGS = trwd_pkg::MAX_ARGS_DEFAULT,
   parameter int TOKEN_WIDTH = trwd_pkg::TOKEN_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   trwd_stream_if.sink req,
   trwd_stream_if.source entry_out
);

   localparam int STORE_WIDTH = (TOKEN_WIDTH < trwd_pkg::TOKEN_PORT_WIDTH) ?
                                TOKEN_WIDTH : trwd_pkg::TOKEN_PORT_WIDTH;
   localparam int COUNT_WIDTH = $clog2(MAX_ARGS + 1);
   localparam int SLOT_IDX_WIDTH = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

   logic primed_ff;
   logic [STORE_WIDTH-1:0] slot_func_ff [WINDOW_SLOTS];
   logic [STORE_WIDTH-1:0] slot_func_in [WINDOW_SLOTS];
   logic [COUNT_WIDTH-1:0] slot_count_ff [WINDOW_SLOTS];
   logic [COUNT_WIDTH-1:0] slot_count_in [WINDOW_SLOTS];
   logic [STORE_WIDTH-1:0] slot_args_ff [WINDOW_SLOTS][MAX_ARGS];
   logic [STORE_WIDTH-1:0] slot_args_in [WINDOW_SLOTS][MAX_ARGS];

   logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] arg_port [trwd_pkg::ARG_PORT_COUNT];
   logic [STORE_WIDTH-1:0] func_tok;
   logic [STORE_WIDTH-1:0] arg_tok [MAX_ARGS];
   logic [STORE_WIDTH-1:0] arg_store [MAX_ARGS];
   logic [COUNT_WIDTH-1:0] count_sat;
   logic [MAX_ARGS-1:0] pos_valid;
   logic [WINDOW_SLOTS-1:0] qualify;
   logic [MAX_ARGS-1:0] diff [WINDOW_SLOTS];
   logic [COUNT_WIDTH-1:0] diff_count [WINDOW_SLOTS];
   logic found;
   logic [COUNT_WIDTH-1:0] best;
   logic [SLOT_IDX_WIDTH-1:0] winner;
   logic accept;
   trwd_pkg::entry_type entry;

   assign arg_port[0] = req.payload.arg_a;
   assign arg_port[1] = req.payload.arg_b;
   assign arg_port[2] = req.payload.arg_c;
   assign arg_port[3] = req.payload.arg_d;
   assign arg_port[4] = req.payload.arg_e;
   assign arg_port[5] = req.payload.arg_f;
   assign arg_port[6] = req.payload.arg_g;
   assign arg_port[7] = req.payload.arg_h;

   assign accept = req.valid && entry_out.ready;
   assign req.ready = entry_out.ready;
   assign entry_out.valid = req.valid;
   assign entry_out.payload = entry;

   always_comb begin
      func_tok = req.payload.func_token[STORE_WIDTH-1:0];
      if (req.payload.arg_total > trwd_pkg::ARG_TOTAL_WIDTH'(MAX_ARGS)) begin
         count_sat = COUNT_WIDTH'(MAX_ARGS);
      end else begin
         count_sat = req.payload.arg_total[COUNT_WIDTH-1:0];
      end
      for (int i = 0; i < MAX_ARGS; i++) begin
         arg_tok[i] = arg_port[i][STORE_WIDTH-1:0];
         pos_valid[i] = COUNT_WIDTH'(i) < count_sat;
         arg_store[i] = pos_valid[i] ? arg_tok[i] : '0;
      end
   end

   always_comb begin
      for (int s = 0; s < WINDOW_SLOTS; s++) begin
         qualify[s] = primed_ff && (count_sat != COUNT_WIDTH'(MAX_ARGS)) &&
                      (slot_func_ff[s] == func_tok) && (slot_count_ff[s] == count_sat);
         diff_count[s] = '0;
         for (int i = 0; i < MAX_ARGS; i++) begin
            diff[s][i] = pos_valid[i] && (slot_args_ff[s][i] != arg_tok[i]);
            diff_count[s] = diff_count[s] + COUNT_WIDTH'(diff[s][i]);
         end
      end
   end

   always_comb begin
      found = 1'b0;
      best = '0;
      winner = '0;
      for (int s = 0; s < WINDOW_SLOTS; s++) begin
         if (qualify[s] && (!found || diff_count[s] < best)) begin
            found = 1'b1;
            best = diff_count[s];
            winner = SLOT_IDX_WIDTH'(s);
         end
      end
   end

   always_comb begin
      entry = '0;
      entry.compressed = found;
      entry.ref_slot = found ? trwd_pkg::REF_SLOT_WIDTH'(winner) : '0;
      entry.start_time = req.payload.start_time;
      entry.duration = req.payload.duration;
      entry.func_token = found ? '0 : trwd_pkg::TOKEN_PORT_WIDTH'(func_tok);
      for (int i = 0; i < MAX_ARGS; i++) begin
         entry.args[i] = trwd_pkg::TOKEN_PORT_WIDTH'(arg_tok[i]);
         entry.emit_mask[i] = found ? diff[winner][i] : pos_valid[i];
      end
   end

   always_comb begin
      slot_func_in = slot_func_ff;
      slot_count_in = slot_count_ff;
      slot_args_in = slot_args_ff;
      if (accept) begin
         slot_func_in[0] = func_tok;
         slot_count_in[0] = count_sat;
         slot_args_in[0] = arg_store;
         for (int s = 1; s < WINDOW_SLOTS; s++) begin
            if (primed_ff) begin
               slot_func_in[s] = slot_func_ff[s-1];
               slot_count_in[s] = slot_count_ff[s-1];
               slot_args_in[s] = slot_args_ff[s-1];
            end else begin
               slot_func_in[s] = func_tok;
               slot_count_in[s] = count_sat;
               slot_args_in[s] = arg_store;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else if (accept) begin
         primed_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_func_ff <= slot_func_in;
      slot_count_ff <= slot_count_in;
      slot_args_ff <= slot_args_in;
   end

endmodule

>>> hw/rtl/trwd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace record window delta: entry queue
// Small first-in first-out buffer of classified records between the front
// end and the result sequencer.
// ----------------------------------------------------------------------------
module trwd_queue #(
   parameter int DEPTH = trwd_pkg::QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   trwd_stream_if.sink push_chan,
   trwd_stream_if.source pop_chan
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   trwd_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff;
   logic [PTR_WIDTH-1:0] wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff;
   logic [PTR_WIDTH-1:0] rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic push;
   logic pop;

   assign push_chan.ready = count_ff != COUNT_WIDTH'(DEPTH);
   assign pop_chan.valid = count_ff != '0;
   assign pop_chan.payload = entries_ff[rd_ptr_ff];
   assign push = push_chan.valid && push_chan.ready;
   assign pop = pop_chan.valid && pop_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_chan.payload;
      end
   end

endmodule

>>> hw/rtl/trwd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace record window delta: result sequencer
// Takes classified records from the queue and sends the header and then each
// selected argument, one response transaction per cycle unless rsp.ready stalls it, through an output
// register.
// ----------------------------------------------------------------------------
module trwd_back (
   input logic clock,
   input logic reset,
   trwd_stream_if.sink entry_in,
   trwd_stream_if.source rsp
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_ARGS
   } phase_type;

   phase_type phase_ff;
   phase_type phase_in;
   trwd_pkg::entry_type cur_ff;
   trwd_pkg::entry_type cur_in;
   logic [trwd_pkg::ARG_PORT_COUNT-1:0] rem_ff;
   logic [trwd_pkg::ARG_PORT_COUNT-1:0] rem_in;
   logic [trwd_pkg::ARG_PORT_COUNT-1:0] rem_next;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   trwd_pkg::rsp_payload_type rsp_payload_ff;
   trwd_pkg::rsp_payload_type rsp_payload_in;
   trwd_pkg::rsp_payload_type result;
   logic [trwd_pkg::ARG_POS_WIDTH-1:0] pos;
   logic out_free;
   logic fire;
   logic done;
   logic take;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_payload_ff;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign fire = out_free && (phase_ff != PH_IDLE);
   assign done = fire && result.last;
   assign entry_in.ready = (phase_ff == PH_IDLE) || done;
   assign take = entry_in.valid && entry_in.ready;

   always_comb begin
      pos = '0;
      for (int i = trwd_pkg::ARG_PORT_COUNT - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            pos = trwd_pkg::ARG_POS_WIDTH'(i);
         end
      end
      rem_next = rem_ff;
      rem_next[pos] = 1'b0;
   end

   always_comb begin
      result = '0;
      result.compressed = cur_ff.compressed;
      result.ref_slot = cur_ff.ref_slot;
      if (phase_ff == PH_HEADER) begin
         result.is_header = 1'b1;
         result.out_start = cur_ff.start_time;
         result.out_duration = cur_ff.duration;
         result.out_func = cur_ff.func_token;
         result.last = rem_ff == '0;
      end else begin
         result.arg_position = pos;
         result.arg_value = cur_ff.args[pos];
         result.last = rem_next == '0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cur_in = cur_ff;
      rem_in = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (take) begin
         phase_in = PH_HEADER;
         cur_in = entry_in.payload;
         rem_in = entry_in.payload.emit_mask;
      end else if (done) begin
         phase_in = PH_IDLE;
      end else if (fire) begin
         case (phase_ff)
            PH_HEADER: begin
               phase_in = PH_ARGS;
            end
            PH_ARGS: begin
               rem_in = rem_next;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in = result;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

>>> test/trwd_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace record window delta: response checker
// Watches both channels. It encodes each accepted record against its own copy
// of the three-slot window, queues the expected response transactions and
// compares every accepted response with the oldest one, field by field.
// ----------------------------------------------------------------------------
module trwd_record_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input trwd_pkg::req_payload_type req_payload,
   input logic rsp_valid,
   input logic rsp_ready,
   input trwd_pkg::rsp_payload_type rsp_payload,
   output int mismatch_count,
   output int pending_count
);

   localparam int SLOTS = trwd_pkg::WINDOW_SLOTS_DEFAULT;
   localparam int ARGS = trwd_pkg::MAX_ARGS_DEFAULT;
   localparam int REPORT_LIMIT = 10;

   logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] window_func [SLOTS];
   logic [trwd_pkg::ARG_TOTAL_WIDTH-1:0] window_count [SLOTS];
   logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] window_args [SLOTS][ARGS];
   logic primed;
   trwd_pkg::rsp_payload_type expected_q [$];
   trwd_pkg::rsp_payload_type want;
   int failures = 0;

   function automatic string describe(input trwd_pkg::rsp_payload_type r);
      return $sformatf({"hdr=%0b comp=%0b slot=%0d start=%0d dur=%0d func=%h",
                        " pos=%0d arg=%h last=%0b"},
                       r.is_header, r.compressed, r.ref_slot, r.out_start,
                       r.out_duration, r.out_func, r.arg_position, r.arg_value, r.last);
   endfunction

   function automatic void encode_record(input trwd_pkg::req_payload_type rec);
      logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] toks [ARGS];
      int cnt;
      logic found;
      int win;
      int best;
      int diff;
      trwd_pkg::rsp_payload_type r;
      toks[0] = rec.arg_a;
      toks[1] = rec.arg_b;
      toks[2] = rec.arg_c;
      toks[3] = rec.arg_d;
      toks[4] = rec.arg_e;
      toks[5] = rec.arg_f;
      toks[6] = rec.arg_g;
      toks[7] = rec.arg_h;
      cnt = (rec.arg_total > ARGS) ? ARGS : int'(rec.arg_total);
      found = 1'b0;
      win = 0;
      best = 0;
      if (primed && cnt < ARGS) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (window_func[s] == rec.func_token && int'(window_count[s]) == cnt) begin
               diff = 0;
               for (int i = 0; i < cnt; i++) begin
                  if (window_args[s][i] != toks[i]) diff++;
               end
               if (!found || diff < best) begin
                  found = 1'b1;
                  best = diff;
                  win = s;
               end
            end
         end
      end

      r = '0;
      r.is_header = 1'b1;
      r.compressed = found;
      r.ref_slot = win[trwd_pkg::REF_SLOT_WIDTH-1:0];
      r.out_start = rec.start_time;
      r.out_duration = rec.duration;
      r.out_func = found ? '0 : rec.func_token;
      expected_q.push_back(r);
      for (int i = 0; i < cnt; i++) begin
         if (!found || window_args[win][i] != toks[i]) begin
            r = '0;
            r.compressed = found;
            r.ref_slot = win[trwd_pkg::REF_SLOT_WIDTH-1:0];
            r.arg_position = i[trwd_pkg::ARG_POS_WIDTH-1:0];
            r.arg_value = toks[i];
            expected_q.push_back(r);
         end
      end
      r = expected_q.pop_back();
      r.last = 1'b1;
      expected_q.push_back(r);

      if (primed) begin
         for (int s = SLOTS - 1; s > 0; s--) begin
            window_func[s] = window_func[s-1];
            window_count[s] = window_count[s-1];
            for (int i = 0; i < ARGS; i++) window_args[s][i] = window_args[s-1][i];
         end
      end
      for (int s = 0; s < (primed ? 1 : SLOTS); s++) begin
         window_func[s] = rec.func_token;
         window_count[s] = cnt[trwd_pkg::ARG_TOTAL_WIDTH-1:0];
         for (int i = 0; i < ARGS; i++) window_args[s][i] = (i < cnt) ? toks[i] : '0;
      end
      primed = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         for (int s = 0; s < SLOTS; s++) begin
            window_func[s] = '0;
            window_count[s] = '0;
            for (int i = 0; i < ARGS; i++) window_args[s][i] = '0;
         end
         primed = 1'b0;
      end else begin
         if (req_valid && req_ready) encode_record(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: unexpected response transaction: %s", $time,
                           describe(rsp_payload));
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.is_header !== want.is_header ||
                   rsp_payload.compressed !== want.compressed ||
                   rsp_payload.ref_slot !== want.ref_slot ||
                   rsp_payload.out_start !== want.out_start ||
                   rsp_payload.out_duration !== want.out_duration ||
                   rsp_payload.out_func !== want.out_func ||
                   rsp_payload.arg_position !== want.arg_position ||
                   rsp_payload.arg_value !== want.arg_value ||
                   rsp_payload.last !== want.last) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("%0t: response transaction mismatch", $time);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(rsp_payload));
                  end
               end
            end
         end
      end
      mismatch_count <= failures;
      pending_count <= expected_q.size();
   end

endmodule

>>> test/tb_trace_record_window_delta_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace record window delta: testbench top
// Drives directed and random trace records into the compressor with random
// gaps and response stalls, and reports the verdict of the response checker.
// ----------------------------------------------------------------------------
module tb_trace_record_window_delta_core ();

   localparam int RANDOM_RECORDS = 460;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_PERCENT = 11;
   localparam logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] FN_READ = 32'd999;
   localparam logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] FN_WRITE = 32'd1000;
   localparam logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] FN_CLOSE = 32'hFFFF_FFFF;
   localparam logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] FN_SEEK = 32'd1002;

   logic clock;
   logic reset;
   logic steady = 1'b0;
   int mismatch_count;
   int pending_count;
   trwd_pkg::req_payload_type history [$];

   trwd_stream_if #(.payload_type(trwd_pkg::req_payload_type)) req_chan ();
   trwd_stream_if #(.payload_type(trwd_pkg::rsp_payload_type)) rsp_chan ();

   trace_record_window_delta_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   trwd_record_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req_payload(req_chan.payload),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_payload(rsp_chan.payload),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   function automatic trwd_pkg::req_payload_type make_record(
      input logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] func,
      input int total
   );
      trwd_pkg::req_payload_type rec;
      rec = '0;
      rec.start_time = $urandom;
      rec.duration = $urandom;
      rec.func_token = func;
      rec.arg_total = total[trwd_pkg::ARG_TOTAL_WIDTH-1:0];
      rec.arg_a = $urandom;
      rec.arg_b = $urandom;
      rec.arg_c = $urandom;
      rec.arg_d = $urandom;
      rec.arg_e = $urandom;
      rec.arg_f = $urandom;
      rec.arg_g = $urandom;
      rec.arg_h = $urandom;
      return rec;
   endfunction

   function automatic trwd_pkg::req_payload_type with_arg(
      input trwd_pkg::req_payload_type rec,
      input int idx,
      input logic [trwd_pkg::TOKEN_PORT_WIDTH-1:0] value
   );
      trwd_pkg::req_payload_type upd;
      upd = rec;
      upd[(trwd_pkg::ARG_PORT_COUNT-1-idx)*trwd_pkg::TOKEN_PORT_WIDTH +:
          trwd_pkg::TOKEN_PORT_WIDTH] = value;
      return upd;
   endfunction

   task automatic send_record(input trwd_pkg::req_payload_type rec);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= rec;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      history.push_front(rec);
      if (history.size() > trwd_pkg::WINDOW_SLOTS_DEFAULT) void'(history.pop_back());
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      trwd_pkg::req_payload_type rec;
      trwd_pkg::req_payload_type base;
      int pick;
      int flips;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The first record matches the checker's cleared window but must still go out in full.
      rec = make_record('0, 0);
      rec.start_time = 32'sh8000_0000;
      rec.duration = 32'sh7FFF_FFFF;
      send_record(rec);
      rec.start_time = 32'sh7FFF_FFFF;
      rec.duration = 32'sh8000_0000;
      send_record(rec);

      base = make_record(FN_READ, 3);
      send_record(base);
      rec = base;
      rec.start_time = '0;
      rec.duration = '1;
      send_record(rec);
      send_record(with_arg(base, 1, ~base.arg_b));
      send_record(base);

      rec = make_record(FN_WRITE, 8);
      for (int i = 0; i < trwd_pkg::ARG_PORT_COUNT; i++) rec = with_arg(rec, i, '1);
      send_record(rec);
      send_record(rec);
      rec.arg_total = 4'hF;
      send_record(rec);
      send_record(base);
      rec.arg_total = 4'd9;
      send_record(rec);

      rec = with_arg(make_record(FN_CLOSE, 1), 0, '0);
      send_record(rec);
      send_record(with_arg(with_arg(with_arg(base, 0, ~base.arg_a), 1, ~base.arg_b),
                           2, ~base.arg_c));
      send_record(rec);

      rec = make_record(FN_SEEK, 7);
      send_record(rec);
      send_record(with_arg(rec, 6, ~rec.arg_g));
      drain_responses();

      for (int n = 0; n < RANDOM_RECORDS; n++) begin
         if (n == 150) drain_responses();
         steady = (n >= 200 && n < 300);
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            rec = history[$urandom_range(0, history.size() - 1)];
            rec.start_time = $urandom;
            rec.duration = $urandom;
            flips = $urandom_range(0, 3);
            repeat (flips)
               rec = with_arg(rec, $urandom_range(0, trwd_pkg::ARG_PORT_COUNT - 1),
                              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3));
         end else if (pick < 88) begin
            rec = make_record(FN_READ + $urandom_range(0, 3), $urandom_range(0, 8));
         end else begin
            rec = make_record($urandom, $urandom_range(0, 15));
         end
         send_record(rec);
      end
      steady = 1'b0;

      drain_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
